// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the biquad filter RTL.
// Each macro assumes signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset.
`define BQ_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
// Next-cycle implication, disabled while in reset.
`define BQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define BQ_ASSERT_SAME(lbl, ante, cons)
`define BQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/bq_pkg.sv -----
// Shared constants and types of the direct-form-II biquad filter.
// Used by the controller, the datapath and the top level; depends on nothing.
package bq_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COEF_FRAC_DEF    = 14;
	localparam int COEF_W           = 16;
	localparam int EXTRA_FRAC       = 8;
	localparam int CFG_IDX_W        = 3;

	// Register indexes, also used to pick a coefficient for the multiplier
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A1 = 3'd0,
		REG_A2 = 3'd1,
		REG_B0 = 3'd2,
		REG_B1 = 3'd3,
		REG_B2 = 3'd4
	} coef_idx_t;

	localparam logic [COEF_W-1:0] COEF_RST_A1 = 16'sd0;
	localparam logic [COEF_W-1:0] COEF_RST_A2 = 16'sd0;
	localparam logic [COEF_W-1:0] COEF_RST_B0 = 16'sd16384;
	localparam logic [COEF_W-1:0] COEF_RST_B1 = 16'sd0;
	localparam logic [COEF_W-1:0] COEF_RST_B2 = 16'sd0;

	// State operand of the multiplier
	typedef enum logic [1:0] {
		SRC_W1,
		SRC_W2,
		SRC_WNEW
	} state_sel_t;

	typedef struct packed {
		logic       load;    // take the input sample, start the feedback sum
		logic       mac;     // accumulate coefficient times state
		logic       sub;     // subtract the product instead of adding
		coef_idx_t  coef;
		state_sel_t src;
		logic       take_w;  // round and clip w, start the output sum
		logic       take_y;  // round and clip y, shift the delay line
	} bq_cmd_t;

	typedef struct packed {
		logic out_busy;      // output register holds a result not yet taken
	} bq_stat_t;

endpackage

// ----- rtl/biquad_lowpass_df2.sv -----
// Top level of the direct-form-II biquad filter: ports, controller and datapath.
// Depends on bq_pkg, bq_ctrl and bq_datapath.
//
// Usage:
//   s_* channel takes one sample per request: tdata = sample_in (signed),
//   tuser = start_of_clip, which clears both delayed states before the sample.
//   m_* channel returns one result per sample: tdata = sample_out (signed,
//   rounded and clipped), tuser = saturated (w or y was clipped).
//   cfg_* channel writes coefficients a1, a2, b0, b1, b2 (indexes 0..4,
//   signed Q2.14 by default); other indexes are dropped. Write only while idle.
// Timing:
//   One multiply-accumulate unit is shared by the five products, so after the
//   accepting edge the sequencer steps through two feedback products, w rounding,
//   three feedforward products and the output load before m_tvalid rises; a new
//   sample waits until then, as s_tready is high only while the sequencer is idle.
//   The next sample is accepted while a result still waits in the output
//   register; if the receiver stalls, the following result holds in the
//   sequencer until the output register frees up.
// Reset:
//   arst_n clears the delay line, loads the coefficient defaults (b0 = 1.0,
//   the rest 0) and empties the output register.
module biquad_lowpass_df2 #(
	parameter int SAMPLE_WIDTH   = bq_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_DEF,
	localparam int TDW           = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [TDW-1:0]                s_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
	input  logic                          s_tuser,   // [0] start_of_clip
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [TDW-1:0]                m_tdata,   // [SAMPLE_WIDTH-1:0] sample_out
	output logic                          m_tuser,   // [0] saturated
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bq_pkg::COEF_W-1:0]     cfg_data
);
	import bq_pkg::*;

	bq_cmd_t                 cmd;
	bq_stat_t                stat;
	logic [SAMPLE_WIDTH-1:0] y_out;

	assign cfg_ready = 1'b1;
	assign m_tdata   = TDW'(y_out);

	bq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bq_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.x_in      (s_tdata[SAMPLE_WIDTH-1:0]),
		.clear_in  (s_tuser),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.y_out     (y_out),
		.sat_out   (m_tuser)
	);

endmodule

// ----- rtl/bq_ctrl.sv -----
// Sequencer of the biquad filter: steps the shared multiply-accumulate unit.
// Depends on bq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  bq_pkg::bq_stat_t  stat,
	output bq_pkg::bq_cmd_t   cmd
);
	import bq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_A1,
		S_A2,
		S_W,
		S_B0,
		S_B1,
		S_B2,
		S_Y
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_A1;
				S_A1:   state_q <= S_A2;
				S_A2:   state_q <= S_W;
				S_W:    state_q <= S_B0;
				S_B0:   state_q <= S_B1;
				S_B1:   state_q <= S_B2;
				S_B2:   state_q <= S_Y;
				S_Y:    if (!stat.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '{load: 1'b0, mac: 1'b0, sub: 1'b0, coef: REG_A1, src: SRC_W1,
			take_w: 1'b0, take_y: 1'b0};
		case (state_q)
			S_IDLE: cmd.load = s_tvalid;
			S_A1: begin
				cmd.mac = 1'b1; cmd.sub = 1'b1; cmd.coef = REG_A1; cmd.src = SRC_W1;
			end
			S_A2: begin
				cmd.mac = 1'b1; cmd.sub = 1'b1; cmd.coef = REG_A2; cmd.src = SRC_W2;
			end
			S_W:  cmd.take_w = 1'b1;
			S_B0: begin
				cmd.mac = 1'b1; cmd.coef = REG_B0; cmd.src = SRC_WNEW;
			end
			S_B1: begin
				cmd.mac = 1'b1; cmd.coef = REG_B1; cmd.src = SRC_W1;
			end
			S_B2: begin
				cmd.mac = 1'b1; cmd.coef = REG_B2; cmd.src = SRC_W2;
			end
			// hold the result until the output register frees up
			S_Y:  cmd.take_y = !stat.out_busy;
			default: ;
		endcase
	end

	`BQ_ASSERT_SAME(a_y_needs_room, cmd.take_y, !stat.out_busy)
	`BQ_ASSERT_NEXT(a_load_then_a1, cmd.load,
		cmd.mac && cmd.sub && (cmd.coef == REG_A1) && (cmd.src == SRC_W1))
	`BQ_ASSERT_NEXT(a_w_then_b0, cmd.take_w,
		cmd.mac && !cmd.sub && (cmd.coef == REG_B0) && (cmd.src == SRC_WNEW))
	`BQ_ASSERT_SAME(a_one_action, 1'b1,
		$onehot0({cmd.load, cmd.mac, cmd.take_w, cmd.take_y}))

endmodule

// ----- rtl/bq_datapath.sv -----
// Datapath of the biquad filter: coefficient registers, delay line, one shared
// multiply-accumulate unit, rounding/clipping and the output register. Uses bq_pkg.
module bq_datapath #(
	parameter int SAMPLE_WIDTH   = bq_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = bq_pkg::COEF_FRAC_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [bq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bq_pkg::COEF_W-1:0]     cfg_data,
	input  logic [SAMPLE_WIDTH-1:0]       x_in,
	input  logic                          clear_in,
	input  bq_pkg::bq_cmd_t               cmd,
	output bq_pkg::bq_stat_t              stat,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [SAMPLE_WIDTH-1:0]       y_out,
	output logic                          sat_out
);
	import bq_pkg::*;

	localparam int SW    = SAMPLE_WIDTH;
	localparam int WW    = SW + EXTRA_FRAC;
	localparam int CF    = COEF_FRAC_BITS;
	localparam int CMAX  = (CF > COEF_W) ? CF : COEF_W;
	localparam int ACC_W = WW + CMAX + 3;
	localparam int PW    = WW + COEF_W;

	localparam logic signed [ACC_W-1:0] ONE   = ACC_W'(1);
	localparam logic signed [ACC_W-1:0] RND_W = ONE <<< (CF - 1);
	localparam logic signed [ACC_W-1:0] RND_Y = ONE <<< (CF + EXTRA_FRAC - 1);
	localparam logic signed [ACC_W-1:0] W_MAX = (ONE <<< (WW - 1)) - ONE;
	localparam logic signed [ACC_W-1:0] W_MIN = -W_MAX - ONE;
	localparam logic signed [ACC_W-1:0] Y_MAX = (ONE <<< (SW - 1)) - ONE;
	localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ONE;

	logic signed [COEF_W-1:0] coef_q [5];
	logic signed [WW-1:0]     w1_q, w2_q, wnew_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     sat_q;

	logic signed [COEF_W-1:0] c_op;
	logic signed [WW-1:0]     s_op;
	logic signed [PW-1:0]     prod;
	logic signed [ACC_W-1:0]  prod_x, x_x, w_full, y_full;
	logic                     w_clip, y_clip;
	logic signed [WW-1:0]     w_sat;
	logic signed [SW-1:0]     y_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[REG_A1] <= COEF_RST_A1;
			coef_q[REG_A2] <= COEF_RST_A2;
			coef_q[REG_B0] <= COEF_RST_B0;
			coef_q[REG_B1] <= COEF_RST_B1;
			coef_q[REG_B2] <= COEF_RST_B2;
		end else if (cfg_valid && (cfg_index inside {[REG_A1:REG_B2]})) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		c_op = coef_q[cmd.coef];
		case (cmd.src)
			SRC_W1:   s_op = w1_q;
			SRC_W2:   s_op = w2_q;
			SRC_WNEW: s_op = wnew_q;
			default:  s_op = w1_q;
		endcase
		prod   = c_op * s_op;
		prod_x = {{(ACC_W - PW){prod[PW-1]}}, prod};
		x_x    = {{(ACC_W - SW){x_in[SW-1]}}, x_in};

		w_full = acc_q >>> CF;
		w_clip = (w_full > W_MAX) || (w_full < W_MIN);
		if (w_full > W_MAX)      w_sat = W_MAX[WW-1:0];
		else if (w_full < W_MIN) w_sat = W_MIN[WW-1:0];
		else                     w_sat = w_full[WW-1:0];

		y_full = acc_q >>> (CF + EXTRA_FRAC);
		y_clip = (y_full > Y_MAX) || (y_full < Y_MIN);
		if (y_full > Y_MAX)      y_sat = Y_MAX[SW-1:0];
		else if (y_full < Y_MIN) y_sat = Y_MIN[SW-1:0];
		else                     y_sat = y_full[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_q <= '0;
			w2_q <= '0;
		end else if (cmd.load && clear_in) begin
			w1_q <= '0;
			w2_q <= '0;
		end else if (cmd.take_y) begin
			w2_q <= w1_q;
			w1_q <= wnew_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= (x_x <<< (CF + EXTRA_FRAC)) + RND_W;
			sat_q <= 1'b0;
		end else if (cmd.mac) begin
			acc_q <= cmd.sub ? (acc_q - prod_x) : (acc_q + prod_x);
		end else if (cmd.take_w) begin
			wnew_q <= w_sat;
			sat_q  <= w_clip;
			acc_q  <= RND_Y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.take_y) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_y) begin
			y_out   <= y_sat;
			sat_out <= sat_q | y_clip;
		end
	end

	assign stat.out_busy = out_valid && !out_ready;

endmodule

// ----- dv/biquad_lowpass_df2_checker.sv -----
// Scoreboard for the direct-form-II biquad: tracks coefficient writes, predicts each output
// sample from the accepted input samples and compares it with the result channel.
// Depends on bq_pkg for widths, register indexes and coefficient defaults.
module biquad_lowpass_df2_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [15:0]                  s_tdata,   // [15:0] sample_in
	input  logic                         s_tuser,   // [0] start_of_clip
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [15:0]                  m_tdata,   // [15:0] sample_out
	input  logic                         m_tuser,   // [0] saturated
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [bq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bq_pkg::COEF_W-1:0]    cfg_data,
	output int                           fail_count,
	output int                           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import bq_pkg::*;

	localparam int SW        = SAMPLE_WIDTH_DEF;
	localparam int COEF_FRAC = COEF_FRAC_DEF;
	localparam int STATE_W   = SW + EXTRA_FRAC;
	localparam int PROD_FRAC = EXTRA_FRAC + COEF_FRAC;
	localparam int REG_COUNT = int'(REG_B2) + 1;

	typedef struct packed {
		logic signed [SW-1:0] value;
		logic                 clipped;
	} filt_out_t;

	logic signed [COEF_W-1:0]  coef [REG_COUNT];
	logic signed [STATE_W-1:0] w_prev1, w_prev2;
	filt_out_t                 filtered_q [$];
	filt_out_t                 want;

	// Advance the filter state by one sample and return the rounded, clipped output.
	function automatic filt_out_t filter_sample(logic signed [SW-1:0] x, logic clear);
		longint    acc, w, y, w_hi, y_hi;
		filt_out_t r;
		if (clear) begin
			w_prev1 = '0;
			w_prev2 = '0;
		end
		r.clipped = 1'b0;
		w_hi = (longint'(1) <<< (STATE_W - 1)) - 1;
		y_hi = (longint'(1) <<< (SW - 1)) - 1;

		acc = (longint'(x) <<< PROD_FRAC)
			- longint'(coef[int'(REG_A1)]) * longint'(w_prev1)
			- longint'(coef[int'(REG_A2)]) * longint'(w_prev2);
		acc += longint'(1) <<< (COEF_FRAC - 1);
		w = acc >>> COEF_FRAC;
		if (w > w_hi) begin
			w = w_hi;
			r.clipped = 1'b1;
		end else if (w < -w_hi - 1) begin
			w = -w_hi - 1;
			r.clipped = 1'b1;
		end

		acc = longint'(coef[int'(REG_B0)]) * w
			+ longint'(coef[int'(REG_B1)]) * longint'(w_prev1)
			+ longint'(coef[int'(REG_B2)]) * longint'(w_prev2);
		acc += longint'(1) <<< (PROD_FRAC - 1);
		y = acc >>> PROD_FRAC;
		if (y > y_hi) begin
			y = y_hi;
			r.clipped = 1'b1;
		end else if (y < -y_hi - 1) begin
			y = -y_hi - 1;
			r.clipped = 1'b1;
		end

		w_prev2 = w_prev1;
		w_prev1 = w[STATE_W-1:0];
		r.value = y[SW-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef[int'(REG_A1)] = COEF_RST_A1;
			coef[int'(REG_A2)] = COEF_RST_A2;
			coef[int'(REG_B0)] = COEF_RST_B0;
			coef[int'(REG_B1)] = COEF_RST_B1;
			coef[int'(REG_B2)] = COEF_RST_B2;
			w_prev1 = '0;
			w_prev2 = '0;
			filtered_q.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			// out-of-range indexes are dropped by the block
			if (cfg_valid && cfg_ready && int'(cfg_index) < REG_COUNT)
				coef[int'(cfg_index)] = cfg_data;

			if (m_tvalid && m_tready) begin
				if (filtered_q.size() == 0) begin
					$error("unexpected result: sample_out %0d saturated %0b",
						$signed(m_tdata[SW-1:0]), m_tuser);
					fail_count++;
				end else begin
					want = filtered_q.pop_front();
					if (m_tdata[SW-1:0] !== want.value) begin
						$error("sample_out: expected %0d, actual %0d",
							$signed(want.value), $signed(m_tdata[SW-1:0]));
						fail_count++;
					end
					if (m_tuser !== want.clipped) begin
						$error("saturated: expected %0b, actual %0b", want.clipped, m_tuser);
						fail_count++;
					end
				end
			end

			if (s_tvalid && s_tready)
				filtered_q.insert(filtered_q.size(),
					filter_sample(s_tdata[SW-1:0], s_tuser));

			outstanding = filtered_q.size();
		end
	end

endmodule

// ----- dv/tb_biquad_lowpass_df2.sv -----
// Top of the biquad filter testbench: clock, reset, sample, coefficient and
// result-stall stimulus, and the final verdict. Depends on bq_pkg, the block and
// biquad_lowpass_df2_checker.
module tb_biquad_lowpass_df2;
	timeunit 1ns;
	timeprecision 1ps;
	import bq_pkg::*;

	localparam int REG_COUNT    = int'(REG_B2) + 1;
	localparam int IDX_MAX      = (1 << CFG_IDX_W) - 1;
	localparam int NUM_PHASES   = 12;
	localparam int PHASE_ITEMS  = 155;
	localparam int DRAIN_CYCLES = 12;

	localparam logic [15:0] POS_MAX = 16'h7fff;
	localparam logic [15:0] NEG_MAX = 16'h8000;
	localparam logic [15:0] ONE_Q14 = 16'h4000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;   // [15:0] sample_in
	logic                 s_tuser;   // [0] start_of_clip
	logic                 m_tvalid;
	logic                 m_tready;
	logic [15:0]          m_tdata;   // [15:0] sample_out
	logic                 m_tuser;   // [0] saturated
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;
	int                   fail_count;
	int                   outstanding;
	logic                 no_idle;

	always #10 clk = ~clk;

	biquad_lowpass_df2 u_top (.*);

	biquad_lowpass_df2_checker u_checker (.*);

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic logic [15:0] draw_sample();
		int pick;
		int tmp;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 3))
				0:       return POS_MAX;
				1:       return NEG_MAX;
				2:       return '0;
				default: return '1;
			endcase
		end else if (pick <= 3) begin
			tmp = int'($urandom_range(0, 4000)) - 2000;
			return tmp[15:0];
		end
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] draw_extreme_coef();
		case ($urandom_range(0, 3))
			0:       return POS_MAX;
			1:       return NEG_MAX;
			2:       return ONE_Q14;
			default: return '0;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_sample(input logic [15:0] smp, input logic clear);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		s_tuser  <= clear;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_all(input logic [15:0] a1, input logic [15:0] a2,
			input logic [15:0] b0, input logic [15:0] b1, input logic [15:0] b2);
		write_coef(REG_A1, a1);
		write_coef(REG_A2, a2);
		write_coef(REG_B0, b0);
		write_coef(REG_B1, b1);
		write_coef(REG_B2, b2);
	endtask

	// Hold off the sample channel until every predicted result has come back.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic program_phase(input int kind);
		logic [15:0] c [REG_COUNT];
		int          tmp;
		int          span;
		case (kind)
			0: begin
				// roughly stable low-pass style feedback
				tmp = $urandom_range(0, 15000);
				c[int'(REG_A2)] = tmp[15:0];
				span = 16384 + tmp - 512;
				tmp = int'($urandom_range(0, 2 * span)) - span;
				c[int'(REG_A1)] = tmp[15:0];
				for (int i = int'(REG_B0); i < REG_COUNT; i++) begin
					tmp = int'($urandom_range(0, 16384)) - 4096;
					c[i] = tmp[15:0];
				end
			end
			1: begin
				for (int i = 0; i < REG_COUNT; i++)
					c[i] = 16'($urandom);
			end
			default: begin
				for (int i = 0; i < REG_COUNT; i++)
					c[i] = draw_extreme_coef();
			end
		endcase
		write_all(c[int'(REG_A1)], c[int'(REG_A2)], c[int'(REG_B0)], c[int'(REG_B1)],
			c[int'(REG_B2)]);
		if ($urandom_range(0, 2) == 0)
			write_coef(CFG_IDX_W'($urandom_range(REG_COUNT, IDX_MAX)), 16'($urandom));
	endtask

	// Result side: stall a random number of cycles before each result.
	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#20_000_000;
		$display("[biquad_lowpass_df2] ERROR");
		$finish;
	end

	initial begin
		int clip_left;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		no_idle   = 1'b0;
		arst_n    = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default coefficients pass the sample straight through
		send_sample(POS_MAX, 1'b1);
		send_sample(NEG_MAX, 1'b0);
		send_sample('0, 1'b0);
		send_sample('1, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'h5555, 1'b0);
		send_sample(16'haaaa, 1'b1);
		settle();

		// strong positive feedback: w runs into its clip level
		write_all(NEG_MAX, NEG_MAX, POS_MAX, POS_MAX, POS_MAX);
		send_sample(POS_MAX, 1'b1);
		repeat (5) send_sample(NEG_MAX, 1'b0);
		send_sample(POS_MAX, 1'b1);
		settle();

		// b0 = b1 = -2 with no feedback: y clips, w does not; index past b2 is dropped
		write_coef(CFG_IDX_W'(REG_COUNT), POS_MAX);
		write_coef(CFG_IDX_W'(IDX_MAX), NEG_MAX);
		write_all('0, '0, NEG_MAX, NEG_MAX, '0);
		send_sample(NEG_MAX, 1'b1);
		send_sample(POS_MAX, 1'b0);
		send_sample(16'h0001, 1'b0);
		send_sample(16'hc000, 1'b0);
		send_sample(16'h3fff, 1'b1);
		send_sample('0, 1'b0);
		settle();

		clip_left = 0;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			no_idle = ($urandom_range(0, 3) == 0);
			program_phase(ph % 3);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (clip_left == 0)
					clip_left = $urandom_range(1, 60);
				send_sample(draw_sample(), (n == 0) || (clip_left == 1) ||
					($urandom_range(0, 49) == 0));
				clip_left--;
			end
			settle();
		end

		if (fail_count == 0 && outstanding == 0)
			$display("[biquad_lowpass_df2] OK");
		else
			$display("[biquad_lowpass_df2] ERROR");
		$finish;
	end

endmodule

// ----- biquad_lowpass_df2.f -----
+incdir+rtl
rtl/bq_pkg.sv
rtl/bq_ctrl.sv
rtl/bq_datapath.sv
rtl/biquad_lowpass_df2.sv
dv/biquad_lowpass_df2_checker.sv
dv/tb_biquad_lowpass_df2.sv
